FILE: hdl/skvt_pkg.sv
// shared types, constants and command codes of the sorted key/value table
package skvt_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 16;

  // command codes
  typedef enum logic [2:0] {
    CMD_PUT_DEF   = 3'd0,
    CMD_PUT_REL   = 3'd1,
    CMD_PUT_UNDEF = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_LOOKUP    = 3'd4
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  // entry state codes
  localparam logic [1:0] ENT_UNDEF = 2'b00;
  localparam logic [1:0] ENT_DEF   = 2'b01;
  localparam logic [1:0] ENT_REL   = 2'b11;

  typedef struct packed {
    logic [2:0]          command;
    logic [KEY_BITS-1:0] key;
    logic [VAL_W-1:0]    value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [5:0]       slot;
    logic [VAL_W-1:0] word_value;
    logic             is_defined;
    logic             is_relative;
    logic [6:0]       entries;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [VAL_W-1:0]    value;
    logic [1:0]          state;
  } entry_t;

  // update control broadcast along the cell row
  typedef struct packed {
    logic   en;
    logic   insert;
    logic   remove;
    logic   modify;
    logic   write_value;
    entry_t entry;
  } cell_ctl_t;

endpackage

FILE: hdl/skvt_cell.sv
// one cell of the sorted row: holds an entry, compares and shifts with neighbors
module skvt_cell (
  input  logic                           clk,
  input  logic                           cmp_en,
  input  logic [skvt_pkg::KEY_BITS-1:0]  cmp_key,
  input  logic                           occupied,
  input  skvt_pkg::cell_ctl_t            ctl,
  input  skvt_pkg::entry_t               left,
  input  logic                           left_lt,
  input  skvt_pkg::entry_t               right,
  output skvt_pkg::entry_t               entry,
  output logic                           lt,
  output logic                           eq
);

  // compare flags, captured when a request is taken
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt <= occupied && (entry.key < cmp_key);
      eq <= occupied && (entry.key == cmp_key);
    end
  end

  // insert shifts up, remove shifts down, modify writes the matching cell
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.insert) begin
        if (!lt) begin
          entry <= left_lt ? ctl.entry : left;
        end
      end else if (ctl.remove) begin
        if (!lt) begin
          entry <= right;
        end
      end else if (ctl.modify && eq) begin
        entry.state <= ctl.entry.state;
        if (ctl.write_value) begin
          entry.value <= ctl.entry.value;
        end
      end
    end
  end

endmodule

FILE: hdl/sorted_key_value_table_core.sv
// Sorted key/value table: a row of compare-and-shift cells kept in key order.
// The request and compare flags are registered when taken; the result is registered by the update.
// Requests are taken one at a time: a compare step across the row,
// then a shift/update step; a stalled result holds the update step.
// Reset clears the entry count and control; cell contents are not cleared.
module sorted_key_value_table_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  skvt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output skvt_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_t;

  state_t                      state;
  state_t                      state_next;
  skvt_pkg::req_t              req_q;
  logic [skvt_pkg::CNT_W-1:0]  count;
  logic [skvt_pkg::CNT_W-1:0]  count_next;
  skvt_pkg::rsp_t              rsp_next;
  skvt_pkg::cell_ctl_t         ctl;

  skvt_pkg::entry_t            cell_entry [skvt_pkg::CAPACITY];
  logic [skvt_pkg::CAPACITY-1:0] cell_lt;
  logic [skvt_pkg::CAPACITY-1:0] cell_eq;
  logic [skvt_pkg::CAPACITY-1:0] bnd;

  logic accept;
  logic upd_go;
  logic hit;
  logic full;
  logic [skvt_pkg::IDX_W-1:0] pos;
  skvt_pkg::entry_t           hit_entry;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign upd_go    = (state == ST_UPD) && (!rsp_valid || !rsp_stall);

  // cell row
  for (genvar i = 0; i < skvt_pkg::CAPACITY; i++) begin : g_cell
    skvt_pkg::entry_t left_e;
    skvt_pkg::entry_t right_e;
    logic             left_lt_e;
    if (i == 0) begin : g_first
      assign left_e    = cell_entry[i];
      assign left_lt_e = 1'b1;
    end else begin : g_mid
      assign left_e    = cell_entry[i-1];
      assign left_lt_e = cell_lt[i-1];
    end
    if (i == skvt_pkg::CAPACITY - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end
    skvt_cell u_cell (
      .clk      (clk),
      .cmp_en   (accept),
      .cmp_key  (req.key),
      .occupied (skvt_pkg::CNT_W'(i) < count),
      .ctl      (ctl),
      .left     (left_e),
      .left_lt  (left_lt_e),
      .right    (right_e),
      .entry    (cell_entry[i]),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i])
    );
    assign bnd[i] = !cell_lt[i] && left_lt_e;
  end

  // match, sorted position and matched entry from the row flags
  always_comb begin
    pos       = '0;
    hit_entry = '0;
    for (int i = 0; i < skvt_pkg::CAPACITY; i++) begin
      if (bnd[i]) begin
        pos = pos | skvt_pkg::IDX_W'(i);
      end
      if (cell_eq[i]) begin
        hit_entry = hit_entry | cell_entry[i];
      end
    end
    hit  = |cell_eq;
    full = (count == skvt_pkg::CNT_W'(skvt_pkg::CAPACITY));
  end

  // update control and result
  always_comb begin
    logic [1:0] ns;
    ns                    = skvt_pkg::ENT_UNDEF;
    ctl                   = '0;
    ctl.en                = upd_go;
    ctl.entry.key         = req_q.key;
    ctl.entry.value       = req_q.value;
    count_next            = count;
    rsp_next              = '0;
    rsp_next.found        = hit;
    case (req_q.command)
      skvt_pkg::CMD_PUT_DEF, skvt_pkg::CMD_PUT_REL, skvt_pkg::CMD_PUT_UNDEF: begin
        if (req_q.command == skvt_pkg::CMD_PUT_DEF) begin
          ns = skvt_pkg::ENT_DEF;
        end else if (req_q.command == skvt_pkg::CMD_PUT_REL) begin
          ns = skvt_pkg::ENT_REL;
        end
        ctl.entry.state = ns;
        if (hit) begin
          ctl.modify      = 1'b1;
          ctl.write_value = (req_q.command != skvt_pkg::CMD_PUT_UNDEF);
          rsp_next.slot   = 6'(pos);
          rsp_next.is_defined  = ns[0];
          rsp_next.is_relative = (ns == skvt_pkg::ENT_REL);
        end else if (full) begin
          rsp_next.status = skvt_pkg::STAT_FULL;
        end else begin
          ctl.insert = 1'b1;
          if (req_q.command == skvt_pkg::CMD_PUT_UNDEF) begin
            ctl.entry.value = '0;
          end
          count_next    = count + skvt_pkg::CNT_W'(1);
          rsp_next.slot = 6'(pos);
          rsp_next.is_defined  = ns[0];
          rsp_next.is_relative = (ns == skvt_pkg::ENT_REL);
        end
      end
      skvt_pkg::CMD_REMOVE: begin
        if (hit) begin
          ctl.remove    = 1'b1;
          count_next    = count - skvt_pkg::CNT_W'(1);
          rsp_next.slot = 6'(pos);
        end else begin
          rsp_next.status = skvt_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        if (hit) begin
          rsp_next.slot        = 6'(pos);
          rsp_next.is_defined  = hit_entry.state[0];
          rsp_next.is_relative = (hit_entry.state == skvt_pkg::ENT_REL);
          if (hit_entry.state[0]) begin
            rsp_next.word_value = hit_entry.value;
          end
        end else begin
          rsp_next.status = skvt_pkg::STAT_NOT_FOUND;
        end
      end
    endcase
    rsp_next.entries = 7'(count_next);
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (upd_go) begin
      rsp <= rsp_next;
    end
  end

endmodule
